// ===== sv/sct_pkg.sv =====
// Shared types, codes and defaults of the session code table.
package sct_pkg;

    // Build defaults
    localparam int MAX_SLOTS_DEF  = 16;
    localparam int CODE_CHARS_DEF = 5;

    // Fixed field widths
    localparam int TIME_W    = 32;
    localparam int LIMIT_W   = 32;
    localparam int COUNT_W   = 5;
    localparam int SEL_W     = 4;
    localparam int ID_W      = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 32;

    // Register reset values
    localparam logic [LIMIT_W-1:0] TIME_LIMIT_RST   = 32'd100000;
    localparam logic [COUNT_W-1:0] SLOTS_IN_USE_RST = 5'd16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_LIMIT   = 1'b0,
        CFG_SLOTS_IN_USE = 1'b1
    } t_cfg_idx;

    // Request opcodes
    typedef enum logic [1:0] {
        OP_OPEN   = 2'd0,
        OP_CHECK  = 2'd1,
        OP_EXPIRE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_DUP    = 3'd2,
        ST_MISS   = 3'd3,
        ST_BYPASS = 3'd4
    } t_status;

    // Configuration seen by the controller
    typedef struct packed {
        logic [LIMIT_W-1:0] time_limit;
        logic [COUNT_W-1:0] slots_in_use;
    } t_cfg;

endpackage

// ===== sv/sct_req_if.sv =====
// Request channel: operation, code, time and slot to clear.
interface sct_req_if #(parameter int CODE_W = 8 * sct_pkg::CODE_CHARS_DEF);
    logic                      valid;
    logic                      ready;
    sct_pkg::t_op              op;
    logic [CODE_W-1:0]         code;
    logic [sct_pkg::TIME_W-1:0] now_ms;
    logic [sct_pkg::SEL_W-1:0]  slot_index;

    modport source (output valid, op, code, now_ms, slot_index, input ready);
    modport sink   (input valid, op, code, now_ms, slot_index, output ready);
endinterface

// ===== sv/sct_rsp_if.sv =====
// Result channel: status and slot number.
interface sct_rsp_if;
    logic                    valid;
    logic                    ready;
    sct_pkg::t_status        status;
    logic [sct_pkg::ID_W-1:0] slot_id;

    modport source (output valid, status, slot_id, input ready);
    modport sink   (input valid, status, slot_id, output ready);
endinterface

// ===== sv/sct_cfg_if.sv =====
// Configuration write channel: register index and data.
interface sct_cfg_if;
    logic                         valid;
    logic                         ready;
    sct_pkg::t_cfg_idx            index;
    logic [sct_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/session_code_table.sv =====
// Session code table: a request scans n slots, n = slots searched (slots_in_use,
// capped at MAX_SLOTS), with one entry memory read per slot; clear, empty-code
// check and an empty table skip the scan. The result is registered and a new
// request is taken while it waits. Reset empties every slot and loads the register
// defaults; the entry memory is not cleared, so no clearing pass is needed.
module session_code_table #(
    parameter int MAX_SLOTS  = sct_pkg::MAX_SLOTS_DEF,
    parameter int CODE_CHARS = sct_pkg::CODE_CHARS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sct_req_if.sink   i_req,
    sct_rsp_if.source o_rsp,
    sct_cfg_if.sink   i_cfg
);
    import sct_pkg::*;

    localparam int CODE_W  = 8 * CODE_CHARS;
    localparam int ENTRY_W = CODE_W + TIME_W;
    localparam int SLOT_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    logic [LIMIT_W-1:0] r_time_limit;
    logic [COUNT_W-1:0] r_slots_in_use;
    t_cfg               w_cfg;

    logic               w_mem_we;
    logic [SLOT_W-1:0]  w_mem_waddr;
    logic [ENTRY_W-1:0] w_mem_wdata;
    logic [SLOT_W-1:0]  w_mem_raddr;
    logic [ENTRY_W-1:0] w_mem_rdata;

    // Configuration registers, always ready
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_limit   <= TIME_LIMIT_RST;
            r_slots_in_use <= SLOTS_IN_USE_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_TIME_LIMIT:   r_time_limit   <= i_cfg.data[LIMIT_W-1:0];
                CFG_SLOTS_IN_USE: r_slots_in_use <= i_cfg.data[COUNT_W-1:0];
            endcase
        end
    end

    assign w_cfg.time_limit   = r_time_limit;
    assign w_cfg.slots_in_use = r_slots_in_use;

    // Sequencer
    sct_ctrl #(
        .MAX_SLOTS  (MAX_SLOTS),
        .CODE_CHARS (CODE_CHARS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    // Slot entry memory
    sct_mem #(
        .DEPTH  (MAX_SLOTS),
        .DATA_W (ENTRY_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

endmodule

// ===== sv/sct_mem.sv =====
// Slot entry memory: code and last-active time, one write and one registered read port.
module sct_mem #(
    parameter int DEPTH  = sct_pkg::MAX_SLOTS_DEF,
    parameter int DATA_W = 8 * sct_pkg::CODE_CHARS_DEF + sct_pkg::TIME_W,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/sct_ctrl.sv =====
// Request sequencer: used bits, slot scan over the entry memory, write-back and result register.
module sct_ctrl #(
    parameter int MAX_SLOTS  = sct_pkg::MAX_SLOTS_DEF,
    parameter int CODE_CHARS = sct_pkg::CODE_CHARS_DEF,
    localparam int CODE_W  = 8 * CODE_CHARS,
    localparam int ENTRY_W = CODE_W + sct_pkg::TIME_W,
    localparam int SLOT_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sct_pkg::t_cfg       i_cfg,
    sct_req_if.sink             i_req,
    sct_rsp_if.source           o_rsp,
    output logic                o_mem_we,
    output logic [SLOT_W-1:0]   o_mem_waddr,
    output logic [ENTRY_W-1:0]  o_mem_wdata,
    output logic [SLOT_W-1:0]   o_mem_raddr,
    input  logic [ENTRY_W-1:0]  i_mem_rdata
);
    import sct_pkg::*;

    localparam int CNT_W = $clog2(MAX_SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    // Control state
    t_state              r_state, n_state;
    logic [MAX_SLOTS-1:0] r_used, n_used;
    logic                r_cmp_valid, n_cmp_valid;
    logic                r_free_hit, n_free_hit;
    logic                r_hit, n_hit;
    logic                r_out_valid, n_out_valid;

    // Request and scan payload
    t_op                 r_op, n_op;
    logic [CODE_W-1:0]   r_key, n_key;
    logic [TIME_W-1:0]   r_now, n_now;
    logic [SEL_W-1:0]    r_sel, n_sel;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_rd_idx, n_rd_idx;
    logic [SLOT_W-1:0]   r_cmp_idx, n_cmp_idx;
    logic [SLOT_W-1:0]   r_free_idx, n_free_idx;
    logic [SLOT_W-1:0]   r_hit_idx, n_hit_idx;
    t_status             r_status, n_status;
    logic [ID_W-1:0]     r_slot_id, n_slot_id;

    // Compare helpers
    logic [CNT_W-1:0]    w_req_count;
    logic [CODE_W-1:0]   w_rd_code;
    logic [TIME_W-1:0]   w_rd_time;
    logic [TIME_W-1:0]   w_idle;
    logic                w_slot_used;
    logic                w_code_eq;
    logic                w_expired;
    logic                w_out_free;
    logic                w_clear_ok;
    logic [31:0]         w_free_num;
    logic [31:0]         w_hit_num;

    assign w_rd_code   = i_mem_rdata[ENTRY_W-1 -: CODE_W];
    assign w_rd_time   = i_mem_rdata[TIME_W-1:0];
    assign w_idle      = r_now - w_rd_time;
    assign w_slot_used = r_used[r_cmp_idx];
    assign w_code_eq   = (w_rd_code == r_key);
    assign w_expired   = (w_idle > i_cfg.time_limit);
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_clear_ok  = (32'(r_sel) < 32'(MAX_SLOTS));
    assign w_free_num  = 32'(r_free_idx);
    assign w_hit_num   = 32'(r_hit_idx);

    // Slots searched: the register value, saturated at the built size
    always_comb begin
        if (32'(i_cfg.slots_in_use) > 32'(MAX_SLOTS)) begin
            w_req_count = CNT_W'(MAX_SLOTS);
        end else begin
            w_req_count = CNT_W'(i_cfg.slots_in_use);
        end
    end

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.status  = r_status;
    assign o_rsp.slot_id = r_slot_id;
    assign o_mem_raddr   = r_rd_idx[SLOT_W-1:0];

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_cmp_valid = 1'b0;
        n_free_hit  = r_free_hit;
        n_hit       = r_hit;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_op        = r_op;
        n_key       = r_key;
        n_now       = r_now;
        n_sel       = r_sel;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_cmp_idx   = r_cmp_idx;
        n_free_idx  = r_free_idx;
        n_hit_idx   = r_hit_idx;
        n_status    = r_status;
        n_slot_id   = r_slot_id;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_hit_idx;
        o_mem_wdata = {r_key, r_now};

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op       = i_req.op;
                    n_key      = i_req.code;
                    n_now      = i_req.now_ms;
                    n_sel      = i_req.slot_index;
                    n_count    = w_req_count;
                    n_rd_idx   = '0;
                    n_free_hit = 1'b0;
                    n_hit      = 1'b0;
                    // clear, empty-code check and an empty table need no scan
                    if (i_req.op == OP_CLEAR || w_req_count == '0 ||
                        (i_req.op == OP_CHECK && i_req.code == '0)) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // issue the next read
                if (r_rd_idx < r_count) begin
                    n_rd_idx    = r_rd_idx + CNT_W'(1);
                    n_cmp_valid = 1'b1;
                    n_cmp_idx   = r_rd_idx[SLOT_W-1:0];
                end
                // compare the entry read last cycle
                if (r_cmp_valid) begin
                    if (!w_slot_used && !r_free_hit) begin
                        n_free_hit = 1'b1;
                        n_free_idx = r_cmp_idx;
                    end
                    if (!r_hit && w_slot_used) begin
                        if ((r_op == OP_EXPIRE && w_expired) ||
                            (r_op != OP_EXPIRE && w_code_eq)) begin
                            n_hit     = 1'b1;
                            n_hit_idx = r_cmp_idx;
                        end
                    end
                    if (r_rd_idx == r_count) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    n_status    = ST_MISS;
                    n_slot_id   = '0;
                    unique case (r_op)
                        OP_OPEN: begin
                            if (!r_free_hit) begin
                                n_status = ST_FULL;
                            end else if (r_hit) begin
                                // refresh the matching slot
                                o_mem_we  = 1'b1;
                                n_status  = ST_DUP;
                                n_slot_id = w_hit_num[ID_W-1:0];
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = r_free_idx;
                                for (int i = 0; i < MAX_SLOTS; i++) begin
                                    if (32'(i) == w_free_num) begin
                                        n_used[i] = 1'b1;
                                    end
                                end
                                n_status  = ST_OK;
                                n_slot_id = w_free_num[ID_W-1:0];
                            end
                        end
                        OP_CHECK: begin
                            if (r_key == '0) begin
                                n_status = ST_BYPASS;
                            end else if (r_hit) begin
                                o_mem_we  = 1'b1;
                                n_status  = ST_OK;
                                n_slot_id = w_hit_num[ID_W-1:0];
                            end
                        end
                        OP_EXPIRE: begin
                            if (r_hit) begin
                                n_status  = ST_OK;
                                n_slot_id = w_hit_num[ID_W-1:0];
                            end
                        end
                        OP_CLEAR: begin
                            if (w_clear_ok) begin
                                for (int i = 0; i < MAX_SLOTS; i++) begin
                                    if (32'(i) == 32'(r_sel)) begin
                                        n_used[i] = 1'b0;
                                    end
                                end
                                n_status  = ST_OK;
                                n_slot_id = ID_W'(r_sel);
                            end
                        end
                    endcase
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_cmp_valid <= 1'b0;
            r_free_hit  <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_cmp_valid <= n_cmp_valid;
            r_free_hit  <= n_free_hit;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_now      <= n_now;
        r_sel      <= n_sel;
        r_count    <= n_count;
        r_rd_idx   <= n_rd_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_free_idx <= n_free_idx;
        r_hit_idx  <= n_hit_idx;
        r_status   <= n_status;
        r_slot_id  <= n_slot_id;
    end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the session code table: directed script, then randomized phases.
module tb_top;
    import sct_pkg::*;

    localparam int NSLOT           = MAX_SLOTS_DEF;
    localparam int CODE_W          = 8 * CODE_CHARS_DEF;
    localparam int POOL_N          = 20;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int STALL_LIMIT     = 4000;

    typedef logic [CODE_W-1:0] t_code;

    typedef struct packed {
        t_status        status;
        logic [ID_W-1:0] slot_id;
    } t_reply;

    // One line of the directed script: a request or a register write
    typedef struct {
        bit               is_cfg;
        t_op              op;
        t_code            code;
        logic [TIME_W-1:0] now;
        logic [SEL_W-1:0]  sel;
        bit               pinned;
        t_status          exp_status;
        logic [ID_W-1:0]  exp_id;
        t_cfg_idx         reg_idx;
        logic [CFG_DAT_W-1:0] reg_val;
    } t_script_row;

    localparam t_code CODE_A   = "ABCDE";
    localparam t_code CODE_B   = "XYZ12";
    localparam t_code CODE_C   = "QWERT";
    localparam t_code CODE_TOP = '1;

    logic i_clk;
    logic i_rst_n;

    sct_req_if #(.CODE_W(CODE_W)) req_bus ();
    sct_rsp_if                    rsp_bus ();
    sct_cfg_if                    cfg_bus ();

    session_code_table uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .i_cfg   (cfg_bus)
    );

    // Mirror of the table and its registers
    bit                tbl_used [NSLOT];
    t_code             tbl_code [NSLOT];
    logic [TIME_W-1:0] tbl_seen [NSLOT];
    logic [LIMIT_W-1:0] idle_limit;
    logic [COUNT_W-1:0] search_span;

    t_reply pending_replies [$];

    // Fixed reply for scripted rows, sent along with the request
    bit              pin_on;
    t_status         pin_status;
    logic [ID_W-1:0] pin_id;

    bit quiet_run;
    int send_calm;
    int fault_count;
    int reply_count;
    int write_count;
    int op_count [4];

    t_code             code_pool [POOL_N];
    t_script_row       script [$];

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Refresh the first searched slot that holds key; slot number or -1
    function automatic int touch_match(t_code key, logic [TIME_W-1:0] stamp, int n);
        int hit;
        hit = -1;
        for (int i = 0; i < n; i++) begin
            if (hit < 0 && tbl_used[i] && tbl_code[i] == key) begin
                tbl_seen[i] = stamp;
                hit = i;
            end
        end
        return hit;
    endfunction

    // Apply one request to the mirror and return the reply it must produce
    function automatic t_reply resolve_request(t_op op, t_code key,
                                               logic [TIME_W-1:0] stamp,
                                               logic [SEL_W-1:0] sel);
        t_reply r;
        int n;
        int pick;
        int hit;
        logic [TIME_W-1:0] idle;
        r.status  = ST_MISS;
        r.slot_id = '0;
        n = (int'(search_span) > NSLOT) ? NSLOT : int'(search_span);
        pick = -1;
        case (op)
            OP_OPEN: begin
                for (int i = 0; i < n; i++)
                    if (pick < 0 && !tbl_used[i]) pick = i;
                if (pick < 0) begin
                    r.status = ST_FULL;
                end else begin
                    hit = touch_match(key, stamp, n);
                    if (hit >= 0) begin
                        r.status  = ST_DUP;
                        r.slot_id = ID_W'(hit);
                    end else begin
                        tbl_used[pick] = 1'b1;
                        tbl_code[pick] = key;
                        tbl_seen[pick] = stamp;
                        r.status  = ST_OK;
                        r.slot_id = ID_W'(pick);
                    end
                end
            end
            OP_CHECK: begin
                if (key == '0) begin
                    r.status = ST_BYPASS;
                end else begin
                    hit = touch_match(key, stamp, n);
                    if (hit >= 0) begin
                        r.status  = ST_OK;
                        r.slot_id = ID_W'(hit);
                    end
                end
            end
            OP_EXPIRE: begin
                // idle time wraps modulo 2^32 and must exceed the limit
                for (int i = 0; i < n; i++) begin
                    idle = stamp - tbl_seen[i];
                    if (pick < 0 && tbl_used[i] && idle > idle_limit) pick = i;
                end
                if (pick >= 0) begin
                    r.status  = ST_OK;
                    r.slot_id = ID_W'(pick);
                end
            end
            OP_CLEAR: begin
                if (int'(sel) < NSLOT) begin
                    tbl_used[sel] = 1'b0;
                    tbl_code[sel] = '0;
                    tbl_seen[sel] = '0;
                    r.status  = ST_OK;
                    r.slot_id = ID_W'(sel);
                end
            end
        endcase
        return r;
    endfunction

    function automatic t_script_row req_row(t_op op, t_code code,
                                            logic [TIME_W-1:0] now,
                                            logic [SEL_W-1:0] sel);
        t_script_row row;
        row.is_cfg     = 1'b0;
        row.op         = op;
        row.code       = code;
        row.now        = now;
        row.sel        = sel;
        row.pinned     = 1'b0;
        row.exp_status = ST_OK;
        row.exp_id     = '0;
        row.reg_idx    = CFG_TIME_LIMIT;
        row.reg_val    = '0;
        return row;
    endfunction

    function automatic t_script_row pinned_row(t_op op, t_code code,
                                               logic [TIME_W-1:0] now,
                                               logic [SEL_W-1:0] sel,
                                               t_status st, logic [ID_W-1:0] id);
        t_script_row row;
        row = req_row(op, code, now, sel);
        row.pinned     = 1'b1;
        row.exp_status = st;
        row.exp_id     = id;
        return row;
    endfunction

    function automatic t_script_row cfg_row(t_cfg_idx idx, logic [CFG_DAT_W-1:0] val);
        t_script_row row;
        row = req_row(OP_OPEN, '0, '0, '0);
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    task automatic log_fault(string what);
        fault_count++;
        if (fault_count <= 10) $display("%s", what);
    endtask

    // Present one request, after an optional gap, and return at its transfer edge
    task automatic issue_request(t_op op, t_code code, logic [TIME_W-1:0] now,
                                 logic [SEL_W-1:0] sel, bit pin, t_status pst,
                                 logic [ID_W-1:0] pid);
        int gap;
        gap = 0;
        if (!quiet_run) begin
            if (send_calm > 0)
                send_calm--;
            else if ($urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 7);
            else if ($urandom_range(0, 29) == 0)
                send_calm = $urandom_range(10, 40);
        end
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.op         <= op;
        req_bus.code       <= code;
        req_bus.now_ms     <= now;
        req_bus.slot_index <= sel;
        pin_on             <= pin;
        pin_status         <= pst;
        pin_id             <= pid;
        @(negedge i_clk);
        while (!req_bus.ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Hold off requests until every outstanding reply has come back;
    // the first look comes after the monitor has logged the last transfer
    task automatic drain_replies();
        req_bus.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_replies.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Register write, only with the table idle
    task automatic write_setting(t_cfg_idx idx, logic [CFG_DAT_W-1:0] val);
        drain_replies();
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(negedge i_clk);
        while (!cfg_bus.ready) @(negedge i_clk);
        @(posedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Reply sink with random stall bursts and calm stretches
    initial begin
        int hold_left;
        int calm_left;
        hold_left = 0;
        calm_left = 0;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (quiet_run) begin
                rsp_bus.ready <= 1'b1;
            end else if (hold_left > 0) begin
                rsp_bus.ready <= 1'b0;
                hold_left--;
            end else if (calm_left > 0) begin
                rsp_bus.ready <= 1'b1;
                calm_left--;
            end else if ($urandom_range(0, 4) == 0) begin
                rsp_bus.ready <= 1'b0;
                hold_left = $urandom_range(1, 7) - 1;
            end else begin
                rsp_bus.ready <= 1'b1;
                if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(20, 80);
            end
        end
    end

    // Transfer monitor: checks replies, predicts requests, tracks registers, watchdog
    always @(posedge i_clk) begin : monitor
        bit moved;
        int stall_cycles;
        t_reply want;
        t_reply got;
        if (i_rst_n) begin
            moved = 1'b0;
            if (rsp_bus.valid && rsp_bus.ready) begin
                moved = 1'b1;
                reply_count++;
                if (pending_replies.size() == 0) begin
                    log_fault($sformatf("reply %0d with nothing pending: status %0d slot %0d",
                                        reply_count, rsp_bus.status, rsp_bus.slot_id));
                end else begin
                    want = pending_replies.pop_front();
                    if (rsp_bus.status !== want.status || rsp_bus.slot_id !== want.slot_id)
                        log_fault($sformatf(
                            "reply %0d: expected status %0d slot %0d, got status %0d slot %0d",
                            reply_count, want.status, want.slot_id,
                            rsp_bus.status, rsp_bus.slot_id));
                end
            end
            if (req_bus.valid && req_bus.ready) begin
                moved = 1'b1;
                op_count[req_bus.op]++;
                got = resolve_request(req_bus.op, req_bus.code, req_bus.now_ms,
                                      req_bus.slot_index);
                if (pin_on) begin
                    got.status  = pin_status;
                    got.slot_id = pin_id;
                end
                pending_replies.push_back(got);
            end
            if (cfg_bus.valid && cfg_bus.ready) begin
                moved = 1'b1;
                write_count++;
                case (cfg_bus.index)
                    CFG_TIME_LIMIT:   idle_limit  = cfg_bus.data;
                    CFG_SLOTS_IN_USE: search_span = cfg_bus.data[COUNT_W-1:0];
                endcase
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("no transfer for %0d cycles, %0d replies outstanding",
                         stall_cycles, pending_replies.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end else begin
            stall_cycles = 0;
        end
    end

    // Stimulus
    initial begin
        int ph;
        int k;
        int roll;
        logic [LIMIT_W-1:0] lim;
        logic [COUNT_W-1:0] span;
        int unsigned stride;
        logic [TIME_W-1:0] wall_ms;
        t_op op;
        t_code code;
        logic [SEL_W-1:0] sel;

        i_rst_n            <= 1'b0;
        req_bus.valid      <= 1'b0;
        req_bus.op         <= OP_OPEN;
        req_bus.code       <= '0;
        req_bus.now_ms     <= '0;
        req_bus.slot_index <= '0;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.index      <= CFG_TIME_LIMIT;
        cfg_bus.data       <= '0;
        pin_on             <= 1'b0;
        pin_status         <= ST_OK;
        pin_id             <= '0;

        quiet_run   = 1'b0;
        send_calm   = 0;
        fault_count = 0;
        reply_count = 0;
        write_count = 0;
        idle_limit  = TIME_LIMIT_RST;
        search_span = SLOTS_IN_USE_RST;
        for (int i = 0; i < NSLOT; i++) begin
            tbl_used[i] = 1'b0;
            tbl_code[i] = '0;
            tbl_seen[i] = '0;
        end
        for (int i = 0; i < 4; i++) op_count[i] = 0;

        // Mostly printable five-letter codes, a few with arbitrary bits
        for (int p = 0; p < POOL_N; p++) begin
            code = '0;
            if (p < 16)
                for (int c = 0; c < CODE_CHARS_DEF; c++)
                    code = {code[CODE_W-9:0], 8'($urandom_range(33, 126))};
            else
                code = t_code'({$urandom, $urandom});
            code_pool[p] = code;
        end

        // Directed script; pinned rows carry the reply read straight off the spec
        script.push_back(pinned_row(OP_CHECK, '0, 32'd0, 4'd0, ST_BYPASS, 4'd0));
        script.push_back(pinned_row(OP_CHECK, CODE_A, 32'd10, 4'd0, ST_MISS, 4'd0));
        script.push_back(pinned_row(OP_EXPIRE, '0, 32'hFFFF_FFFF, 4'd0, ST_MISS, 4'd0));
        script.push_back(pinned_row(OP_OPEN, CODE_A, 32'd1000, 4'd0, ST_OK, 4'd0));
        script.push_back(pinned_row(OP_OPEN, CODE_A, 32'd2000, 4'd0, ST_DUP, 4'd0));
        script.push_back(req_row(OP_OPEN, '0, 32'd3000, 4'd0));        // empty code stored
        script.push_back(req_row(OP_CHECK, CODE_A, 32'd5000, 4'd0));
        script.push_back(req_row(OP_OPEN, CODE_TOP, 32'd6000, 4'd0));
        script.push_back(req_row(OP_CHECK, CODE_TOP, 32'd6500, 4'd0));
        script.push_back(req_row(OP_EXPIRE, '0, 32'd103001, 4'd0));    // one past the limit
        script.push_back(pinned_row(OP_CLEAR, '0, 32'd0, 4'd1, ST_OK, 4'd1));
        script.push_back(req_row(OP_OPEN, CODE_B, 32'd104000, 4'd0));  // reuses cleared slot
        script.push_back(pinned_row(OP_CLEAR, '0, 32'd0, 4'd15, ST_OK, 4'd15));
        script.push_back(req_row(OP_CHECK, 40'h1, 32'd0, 4'd0));
        script.push_back(cfg_row(CFG_SLOTS_IN_USE, 32'd1));
        script.push_back(pinned_row(OP_OPEN, CODE_C, 32'd105000, 4'd0, ST_FULL, 4'd0));
        script.push_back(req_row(OP_CHECK, CODE_B, 32'd105000, 4'd0)); // outside search span
        script.push_back(cfg_row(CFG_TIME_LIMIT, 32'd0));
        script.push_back(req_row(OP_EXPIRE, '0, 32'd5000, 4'd0));      // zero idle, not expired
        script.push_back(req_row(OP_EXPIRE, '0, 32'd0, 4'd0));         // idle wraps around
        script.push_back(cfg_row(CFG_TIME_LIMIT, 32'hFFFF_FFFF));
        script.push_back(req_row(OP_EXPIRE, '0, 32'd4999, 4'd0));
        script.push_back(cfg_row(CFG_SLOTS_IN_USE, 32'd16));
        script.push_back(cfg_row(CFG_TIME_LIMIT, 32'd100000));
        script.push_back(req_row(OP_OPEN, CODE_C, 32'd200000, 4'd0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[r]) begin
            if (script[r].is_cfg)
                write_setting(script[r].reg_idx, script[r].reg_val);
            else
                issue_request(script[r].op, script[r].code, script[r].now, script[r].sel,
                              script[r].pinned, script[r].exp_status, script[r].exp_id);
        end

        // Random phases, each under its own register setting
        wall_ms = 32'd300000;
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin lim = 32'd200;        span = 5'd16; stride = 60;     end
                1: begin lim = 32'd0;          span = 5'd16; stride = 3;      end
                2: begin lim = 32'hFFFF_FFFF;  span = 5'd16; stride = 5000;   end
                3: begin lim = 32'd500;        span = 5'd1;  stride = 200;    end
                4: begin lim = 32'd1000;       span = 5'd4;  stride = 400;    end
                5: begin
                    lim    = $urandom;
                    span   = COUNT_W'($urandom_range(1, NSLOT));
                    stride = 100000;
                end
                6: begin
                    lim     = 32'd300;
                    span    = 5'd8;
                    stride  = 100;
                    wall_ms = 32'hFFFF_FE00;    // cross the 2^32 wrap
                end
                default: begin lim = 32'd250;  span = 5'd16; stride = 80;     end
            endcase
            write_setting(CFG_TIME_LIMIT, lim);
            write_setting(CFG_SLOTS_IN_USE, CFG_DAT_W'(span));
            if (ph == PHASES - 1) quiet_run = 1'b1;

            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 30)      op = OP_OPEN;
                else if (roll < 62) op = OP_CHECK;
                else if (roll < 80) op = OP_EXPIRE;
                else                op = OP_CLEAR;

                roll = $urandom_range(0, 99);
                if (roll < 80)      code = code_pool[$urandom_range(0, POOL_N - 1)];
                else if (roll < 85) code = '0;
                else                code = t_code'({$urandom, $urandom});

                if ($urandom_range(0, 49) == 0) wall_ms = $urandom;
                else                            wall_ms += $urandom_range(0, stride);

                if ($urandom_range(0, 1) == 1)
                    sel = SEL_W'($urandom_range(0, int'(span) - 1));
                else
                    sel = SEL_W'($urandom_range(0, NSLOT - 1));

                issue_request(op, code, wall_ms, sel, 1'b0, ST_OK, '0);

                // let the table run dry once in the middle of a phase
                if (ph == 0 && k == ITEMS_PER_PHASE / 2) drain_replies();
            end
        end

        drain_replies();
        repeat (NSLOT + 8) @(posedge i_clk);

        $display("covered %0d requests: %0d open, %0d check, %0d expire, %0d clear",
                 op_count[OP_OPEN] + op_count[OP_CHECK] + op_count[OP_EXPIRE]
                 + op_count[OP_CLEAR], op_count[OP_OPEN], op_count[OP_CHECK],
                 op_count[OP_EXPIRE], op_count[OP_CLEAR]);
        $display("%0d replies checked across %0d register writes, %0d faults",
                 reply_count, write_count, fault_count);
        if (fault_count == 0 && pending_replies.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
